FILE: hw/rtl/assert_macros.svh
// shared assertion macros for the receiver checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CFTR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define CFTR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: hw/rtl/cftr_pkg.sv
package cftr_pkg;

   // frame geometry
   localparam int PAYLOAD_BYTES = 25;
   localparam int FRAME_LEN     = PAYLOAD_BYTES + 7;
   localparam int STORE_DEPTH   = FRAME_LEN;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
   localparam int WORD_BYTES    = 24;
   localparam int PAY_IDX_W     = $clog2(WORD_BYTES);
   localparam int WORD_COUNT    = 6;

   // byte offsets inside an aligned frame
   localparam logic [ADDR_W-1:0] STATUS_OFF   = ADDR_W'(2);
   localparam logic [ADDR_W-1:0] LEN_OFF      = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] PAY_FIRST    = ADDR_W'(5);
   localparam logic [ADDR_W-1:0] PAY_LAST     = ADDR_W'(5 + WORD_BYTES - 1);
   localparam logic [ADDR_W-1:0] CRC_LAST_OFF = ADDR_W'(FRAME_LEN - 3);
   localparam logic [ADDR_W-1:0] CRC_LO_OFF   = ADDR_W'(FRAME_LEN - 2);
   localparam logic [ADDR_W-1:0] CRC_HI_OFF   = ADDR_W'(FRAME_LEN - 1);

   // fill thresholds
   localparam logic [FILL_W-1:0] MIN_SCAN  = FILL_W'(7);
   localparam logic [FILL_W-1:0] HDR_LEN   = FILL_W'(5);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STORE_DEPTH);

   // byte codes
   localparam logic [7:0] SOF0      = 8'hAA;
   localparam logic [7:0] SOF1      = 8'h55;
   localparam logic [7:0] LEN_CODE  = 8'(PAYLOAD_BYTES);
   localparam logic [7:0] STATUS_OK = 8'h00;

   // crc-16-ccitt
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic [4:0] DROP_MAX = 5'd31;

   typedef struct packed {
      logic init;
      logic step;
   } crc_ctl_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

endpackage

FILE: hw/rtl/cftr_store.sv
module cftr_store
   import cftr_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cftr_crc.sv
module cftr_crc
   import cftr_pkg::*;
(
   input  logic        clock,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data,
   output logic [15:0] crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   // msb-first byte update
   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((v & CRC_TOP) != 16'h0000) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

   // seed or fold one byte
   always_comb begin
      crc_in = crc_ff;
      if (ctl.init) begin
         crc_in = CRC_INIT;
      end else if (ctl.step) begin
         crc_in = crc_next(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

   assign crc = crc_ff;

endmodule

FILE: hw/rtl/cftr_seq.sv
module cftr_seq
   import cftr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_command_sent,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_frame_valid,
   output logic [4:0]        rsp_drop_count,
   output logic              rsp_link_ok,
   output logic              rsp_resend_request,
   output logic [31:0]       rsp_word [WORD_COUNT],
   output store_wr_type      mem_wr,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [7:0]        mem_q,
   output crc_ctl_type       crc_ctl,
   input  logic [15:0]       crc_val
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CHECK     = 3'd1;
   localparam logic [2:0] ST_SCAN      = 3'd2;
   localparam logic [2:0] ST_HDR_ISSUE = 3'd3;
   localparam logic [2:0] ST_HDR       = 3'd4;
   localparam logic [2:0] ST_CRC       = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              link_ff, link_in;
   logic [ADDR_W-1:0] sc_ff, sc_in;
   logic [7:0]        prev_ff, prev_in;
   logic [7:0]        status_ff, status_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic              cmd_ff, cmd_in;
   logic [4:0]        drops_ff, drops_in;
   logic              good_ff, good_in;
   logic              resend_ff, resend_in;
   logic [7:0]        pay_ff [WORD_BYTES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_frame_ff;
   logic [4:0]        rsp_drops_ff;
   logic              rsp_link_ff;
   logic              rsp_resend_ff;
   logic [31:0]       rsp_word_ff [WORD_COUNT];
   logic [31:0]       rsp_word_in [WORD_COUNT];

   logic              rsp_load;
   logic              do_drop;
   logic              pay_we;
   logic [PAY_IDX_W-1:0] pay_idx;
   logic [ADDR_W-1:0] rd_off;
   logic [ADDR_W-1:0] fill_off;
   logic [FILL_W-1:0] rest;

   // circular add, both operands below the depth
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (ADDR_W + 1)'(STORE_DEPTH)) begin
         s = s - (ADDR_W + 1)'(STORE_DEPTH);
      end
      return s[ADDR_W-1:0];
   endfunction

   assign fill_off    = (fill_ff == FILL_FULL) ? '0 : ADDR_W'(fill_ff);
   assign rest        = fill_ff - FILL_W'(sc_ff - ADDR_W'(1));
   assign pay_idx     = PAY_IDX_W'(sc_ff - PAY_FIRST);
   assign mem_rd_addr = wrap_add(head_ff, rd_off);

   // frame search sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      link_in      = link_ff;
      sc_in        = sc_ff;
      prev_in      = prev_ff;
      status_in    = status_ff;
      crc_lo_in    = crc_lo_ff;
      cmd_in       = cmd_ff;
      drops_in     = drops_ff;
      good_in      = good_ff;
      resend_in    = resend_ff;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = wrap_add(head_ff, fill_off);
      mem_wr.data  = req_rx_byte;
      rd_off       = '0;
      crc_ctl.init = 1'b0;
      crc_ctl.step = 1'b0;
      pay_we       = 1'b0;
      do_drop      = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_wr.en = 1'b1;
               cmd_in    = req_command_sent;
               drops_in  = '0;
               good_in   = 1'b0;
               resend_in = 1'b0;
               if (fill_ff == FILL_FULL) begin
                  head_in = wrap_add(head_ff, ADDR_W'(1));
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fill_ff >= MIN_SCAN) begin
               rd_off   = '0;
               sc_in    = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (sc_ff != '0 && prev_ff == SOF0 && mem_q == SOF1) begin
               // align to the start pattern
               head_in = wrap_add(head_ff, sc_ff - ADDR_W'(1));
               fill_in = rest;
               if (rest < HDR_LEN) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_HDR_ISSUE;
               end
            end else if (FILL_W'(sc_ff) + FILL_W'(1) == fill_ff) begin
               // no pattern, keep the newest byte
               head_in  = wrap_add(head_ff, ADDR_W'(fill_ff - FILL_W'(1)));
               fill_in  = FILL_W'(1);
               state_in = ST_DONE;
            end else begin
               prev_in = mem_q;
               sc_in   = sc_ff + ADDR_W'(1);
               rd_off  = sc_ff + ADDR_W'(1);
            end
         end
         ST_HDR_ISSUE: begin
            rd_off   = LEN_OFF;
            state_in = ST_HDR;
         end
         ST_HDR: begin
            if (mem_q != LEN_CODE) begin
               do_drop  = 1'b1;
               state_in = ST_CHECK;
            end else if (fill_ff != FILL_FULL) begin
               state_in = ST_DONE;
            end else begin
               rd_off       = STATUS_OFF;
               sc_in        = STATUS_OFF;
               crc_ctl.init = 1'b1;
               state_in     = ST_CRC;
            end
         end
         ST_CRC: begin
            // one byte per cycle through the crc unit
            if (sc_ff <= CRC_LAST_OFF) begin
               crc_ctl.step = 1'b1;
            end
            if (sc_ff == STATUS_OFF) begin
               status_in = mem_q;
            end
            if (sc_ff >= PAY_FIRST && sc_ff <= PAY_LAST) begin
               pay_we = 1'b1;
            end
            if (sc_ff == CRC_LO_OFF) begin
               crc_lo_in = mem_q;
            end
            if (sc_ff == CRC_HI_OFF) begin
               if ({mem_q, crc_lo_ff} == crc_val) begin
                  link_in   = 1'b1;
                  good_in   = 1'b1;
                  resend_in = (status_ff != STATUS_OK) && cmd_ff;
                  fill_in   = '0;
                  state_in  = ST_DONE;
               end else begin
                  do_drop  = 1'b1;
                  state_in = ST_CHECK;
               end
            end else begin
               sc_in  = sc_ff + ADDR_W'(1);
               rd_off = sc_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // drop one byte of a bad frame
      if (do_drop) begin
         link_in = 1'b0;
         head_in = wrap_add(head_ff, ADDR_W'(1));
         fill_in = fill_ff - FILL_W'(1);
         if (drops_ff != DROP_MAX) begin
            drops_in = drops_ff + 5'd1;
         end
      end
   end

   // result words, zero unless a frame completed
   always_comb begin
      for (int k = 0; k < WORD_COUNT; k++) begin
         rsp_word_in[k] = good_ff ? {pay_ff[4*k+3], pay_ff[4*k+2],
                                     pay_ff[4*k+1], pay_ff[4*k]} : '0;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         link_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         link_ff      <= link_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working data
   always_ff @(posedge clock) begin
      sc_ff     <= sc_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      crc_lo_ff <= crc_lo_in;
      cmd_ff    <= cmd_in;
      drops_ff  <= drops_in;
      good_ff   <= good_in;
      resend_ff <= resend_in;
      if (pay_we) begin
         pay_ff[pay_idx] <= mem_q;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_ff  <= good_ff;
         rsp_drops_ff  <= drops_ff;
         rsp_link_ff   <= link_ff;
         rsp_resend_ff <= resend_ff;
         rsp_word_ff   <= rsp_word_in;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_valid    = rsp_frame_ff;
   assign rsp_drop_count     = rsp_drops_ff;
   assign rsp_link_ok        = rsp_link_ff;
   assign rsp_resend_request = rsp_resend_ff;
   assign rsp_word           = rsp_word_ff;

endmodule

FILE: hw/rtl/crc_framed_telemetry_receiver.sv
// channel  direction  handshake            beat
// req      in         req_valid/req_stall  req_rx_byte, req_command_sent
// rsp      out        rsp_valid/rsp_stall  frame flag, drop count, link, resend, six words
//
// one byte per beat, each byte gives exactly one result beat; with fewer than seven bytes held
// no search runs, else each search pass walks the held bytes on the byte store read port,
// then reads the length byte and, once a full frame is held, walks the crc over it;
// every dropped frame adds one more pass
// reset empties the buffer and sets link_ok; the byte store needs no clearing
// req_stall is high while a byte is in work; a stalled result holds back the next one only
module crc_framed_telemetry_receiver
   import cftr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_command_sent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_valid,
   output logic [4:0]  rsp_drop_count,
   output logic        rsp_link_ok,
   output logic        rsp_resend_request,
   output logic [31:0] rsp_word_a,
   output logic [31:0] rsp_word_b,
   output logic [31:0] rsp_word_c,
   output logic [31:0] rsp_word_d,
   output logic [31:0] rsp_word_e,
   output logic [31:0] rsp_word_f
);

   store_wr_type      mem_wr;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_q;
   crc_ctl_type       crc_ctl;
   logic [15:0]       crc_val;
   logic [31:0]       rsp_word [WORD_COUNT];

   // byte buffer
   cftr_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_q)
   );

   // single crc unit
   cftr_crc u_crc (
      .clock (clock),
      .ctl   (crc_ctl),
      .data  (mem_q),
      .crc   (crc_val)
   );

   // sequencer and result register
   cftr_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_command_sent   (req_command_sent),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_valid    (rsp_frame_valid),
      .rsp_drop_count     (rsp_drop_count),
      .rsp_link_ok        (rsp_link_ok),
      .rsp_resend_request (rsp_resend_request),
      .rsp_word           (rsp_word),
      .mem_wr             (mem_wr),
      .mem_rd_addr        (mem_rd_addr),
      .mem_q              (mem_q),
      .crc_ctl            (crc_ctl),
      .crc_val            (crc_val)
   );

   assign rsp_word_a = rsp_word[0];
   assign rsp_word_b = rsp_word[1];
   assign rsp_word_c = rsp_word[2];
   assign rsp_word_d = rsp_word[3];
   assign rsp_word_e = rsp_word[4];
   assign rsp_word_f = rsp_word[5];

endmodule

FILE: hw/rtl/cftr_checker.sv
`include "assert_macros.svh"

module cftr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_valid,
   input logic [4:0]  rsp_drop_count,
   input logic        rsp_link_ok,
   input logic        rsp_resend_request,
   input logic [31:0] rsp_word_a,
   input logic [31:0] rsp_word_b,
   input logic [31:0] rsp_word_c,
   input logic [31:0] rsp_word_d,
   input logic [31:0] rsp_word_e,
   input logic [31:0] rsp_word_f
);

   // a stalled result beat stays offered
   `CFTR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // a byte just taken leaves the input busy on the next cycle
   `CFTR_ASSERT_NXT(a_busy_after_take, req_valid && !req_stall, req_stall)

   // no frame means no payload and no resend
   `CFTR_ASSERT_IMP(a_quiet_payload, rsp_valid && !rsp_frame_valid, (rsp_word_a == 32'h0) && (rsp_word_b == 32'h0) && (rsp_word_c == 32'h0) && (rsp_word_d == 32'h0) && (rsp_word_e == 32'h0) && (rsp_word_f == 32'h0) && !rsp_resend_request)

   // a good frame always leaves the link up
   `CFTR_ASSERT_IMP(a_good_link, rsp_valid && rsp_frame_valid, rsp_link_ok)

   // drops without a good frame leave the link down
   `CFTR_ASSERT_IMP(a_drop_link, rsp_valid && !rsp_frame_valid && (rsp_drop_count != 5'd0), !rsp_link_ok)

endmodule

bind crc_framed_telemetry_receiver cftr_checker u_checker (.*);
